FILE: hw/rtl/psdu_pkg.sv
// Shared widths and the t = 1.0 constant for the point-segment distance unit.
// No dependencies.
package psdu_pkg;
   localparam int unsigned CoordW  = 16;
   localparam int unsigned DiffW   = 17;
   localparam int unsigned ProdW   = 34;
   localparam int unsigned DotW    = 36;
   localparam int unsigned TFracW  = 16;
   localparam int unsigned TW      = 17;
   localparam int unsigned OffW    = 36;
   localparam int unsigned MagW    = 26;
   localparam int unsigned RadW    = 53;
   localparam int unsigned RootW   = 54;
   localparam int unsigned SqSteps = 27;
   localparam int unsigned DistW   = 17;
   localparam logic [TW-1:0] TOne  = 17'h10000;
endpackage

FILE: hw/rtl/point_segment_distance_unit.sv
// Point to segment distance, fully pipelined, one beat per cycle while rsp is not stalled.
// Depends on psdu_pkg.
//
//  channel | direction | tdata fields (low bit up)
//  req     | in        | seg_start_x, seg_start_y, seg_end_x, seg_end_y, query_x, query_y
//  rsp     | out       | distance (17 bits, zero padded to 24)
//
// One beat enters per cycle while rsp is not stalled; the pipe is 4 setup stages,
// 16 divider stages at one quotient bit each, 4 offset stages, 27 square root stages at
// one root bit each and one output register. The divider and root pipelines set the depth.
// Reset clears the valid bits only. A stalled output freezes the whole pipe,
// so nothing is dropped or repeated; req_tready falls only while rsp is stalled.
module point_segment_distance_unit
   import psdu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                                   // query_x, query_y (16 bits each)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // distance [16:0], zeros above
);
   localparam int unsigned DivSteps = TFracW;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // stage A: input capture
   logic                     a_v_ff;
   logic signed [CoordW-1:0] a_sx_ff, a_sy_ff, a_ex_ff, a_ey_ff, a_qx_ff, a_qy_ff;
   // stage B: difference vectors
   logic                     b_v_ff;
   logic signed [DiffW-1:0]  b_abx_ff, b_aby_ff, b_avx_ff, b_avy_ff;
   // stage C: products
   logic                     c_v_ff;
   logic signed [DiffW-1:0]  c_abx_ff, c_aby_ff, c_avx_ff, c_avy_ff;
   logic signed [ProdW-1:0]  c_px_ff, c_py_ff, c_qx_ff, c_qy_ff;
   // stage D: dot product, squared length, clamp decision
   logic                     d_v_ff, d_zero_ff, d_one_ff;
   logic signed [DiffW-1:0]  d_abx_ff, d_aby_ff, d_avx_ff, d_avy_ff;
   logic [DotW-1:0]          d_rem_ff, d_den_ff;
   // divider pipeline
   logic                     dv_v_ff    [DivSteps];
   logic                     dv_zero_ff [DivSteps];
   logic                     dv_one_ff  [DivSteps];
   logic signed [DiffW-1:0]  dv_abx_ff [DivSteps], dv_aby_ff [DivSteps];
   logic signed [DiffW-1:0]  dv_avx_ff [DivSteps], dv_avy_ff [DivSteps];
   logic [DotW-1:0]          dv_rem_ff [DivSteps], dv_den_ff [DivSteps];
   logic [TFracW-1:0]        dv_q_ff   [DivSteps];
   logic [DotW-1:0]          dv_rem_in [DivSteps];
   logic [TFracW-1:0]        dv_q_in   [DivSteps];
   // stage E: t times segment vector
   logic                     e_v_ff;
   logic signed [DiffW-1:0]  e_avx_ff, e_avy_ff;
   logic signed [OffW-1:0]   e_tx_ff, e_ty_ff;
   // stage F: truncated offset magnitudes
   logic                     f_v_ff;
   logic [MagW-1:0]          f_mx_ff, f_my_ff;
   // stage G: squares
   logic                     g_v_ff;
   logic [2*MagW-1:0]        g_sx_ff, g_sy_ff;
   // stage H: radicand
   logic                     h_v_ff;
   logic [RadW-1:0]          h_n_ff;
   // root pipeline
   logic                     sq_v_ff [SqSteps];
   logic [RadW-1:0]          sq_n_ff [SqSteps], sq_n_in [SqSteps];
   logic [RootW-1:0]         sq_r_ff [SqSteps], sq_r_in [SqSteps];
   // output
   logic                     o_v_ff;
   logic [DistW-1:0]         o_dist_ff;

   // combinational helpers
   logic signed [DotW-1:0]   num_c;
   logic [DotW-1:0]          den_c;
   logic                     zero_c, one_c;
   logic [TW-1:0]            t_c;
   logic signed [OffW-1:0]   dx_c, dy_c;
   logic [OffW-1:0]          ax_c, ay_c;

   always_comb begin
      num_c  = DotW'(c_px_ff) + DotW'(c_py_ff);
      den_c  = DotW'($unsigned(c_qx_ff)) + DotW'($unsigned(c_qy_ff));
      zero_c = (den_c == '0) || num_c[DotW-1] || (num_c == '0);
      one_c  = !zero_c && ($unsigned(num_c) >= den_c);
   end

   // restoring division, one quotient bit per stage; remainder stays below den
   always_comb begin
      for (int k = 0; k < DivSteps; k++) begin
         logic [DotW:0]      r2;
         logic [DotW-1:0]    den;
         logic [TFracW-1:0]  q;
         r2  = (k == 0) ? {d_rem_ff, 1'b0} : {dv_rem_ff[k-1], 1'b0};
         den = (k == 0) ? d_den_ff : dv_den_ff[k-1];
         q   = (k == 0) ? '0 : dv_q_ff[k-1];
         if (r2 >= {1'b0, den}) begin
            dv_rem_in[k] = DotW'(r2 - {1'b0, den});
            dv_q_in[k]   = {q[TFracW-2:0], 1'b1};
         end else begin
            dv_rem_in[k] = DotW'(r2);
            dv_q_in[k]   = {q[TFracW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      priority if (dv_one_ff[DivSteps-1]) t_c = TOne;
      else if (dv_zero_ff[DivSteps-1])    t_c = '0;
      else                                t_c = TW'(dv_q_ff[DivSteps-1]);
      dx_c = (OffW'(e_avx_ff) <<< TFracW) - e_tx_ff;
      dy_c = (OffW'(e_avy_ff) <<< TFracW) - e_ty_ff;
      ax_c = dx_c[OffW-1] ? $unsigned(-dx_c) : $unsigned(dx_c);
      ay_c = dy_c[OffW-1] ? $unsigned(-dy_c) : $unsigned(dy_c);
   end

   // bitwise square root, one root bit per stage
   always_comb begin
      for (int k = 0; k < SqSteps; k++) begin
         logic [RadW-1:0]  n;
         logic [RootW-1:0] r, b, rb;
         n  = (k == 0) ? h_n_ff : sq_n_ff[k-1];
         r  = (k == 0) ? '0 : sq_r_ff[k-1];
         b  = RootW'(1) << (2 * (SqSteps - 1 - k));
         rb = r + b;
         if (RootW'(n) >= rb) begin
            sq_n_in[k] = RadW'(RootW'(n) - rb);
            sq_r_in[k] = (r >> 1) + b;
         end else begin
            sq_n_in[k] = n;
            sq_r_in[k] = r >> 1;
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0; b_v_ff <= 1'b0; c_v_ff <= 1'b0; d_v_ff <= 1'b0;
         e_v_ff <= 1'b0; f_v_ff <= 1'b0; g_v_ff <= 1'b0; h_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
         for (int k = 0; k < DivSteps; k++) dv_v_ff[k] <= 1'b0;
         for (int k = 0; k < SqSteps; k++)  sq_v_ff[k] <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_tvalid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
         dv_v_ff[0] <= d_v_ff;
         for (int k = 1; k < DivSteps; k++) dv_v_ff[k] <= dv_v_ff[k-1];
         e_v_ff <= dv_v_ff[DivSteps-1];
         f_v_ff <= e_v_ff;
         g_v_ff <= f_v_ff;
         h_v_ff <= g_v_ff;
         sq_v_ff[0] <= h_v_ff;
         for (int k = 1; k < SqSteps; k++) sq_v_ff[k] <= sq_v_ff[k-1];
         o_v_ff <= sq_v_ff[SqSteps-1];
      end
   end

   // payload: advance all stages together, hold on stall
   always_ff @(posedge clock) begin
      if (adv) begin
         a_sx_ff <= req_tdata[15:0];  a_sy_ff <= req_tdata[31:16];
         a_ex_ff <= req_tdata[47:32]; a_ey_ff <= req_tdata[63:48];
         a_qx_ff <= req_tdata[79:64]; a_qy_ff <= req_tdata[95:80];

         b_abx_ff <= DiffW'(a_ex_ff) - DiffW'(a_sx_ff);
         b_aby_ff <= DiffW'(a_ey_ff) - DiffW'(a_sy_ff);
         b_avx_ff <= DiffW'(a_qx_ff) - DiffW'(a_sx_ff);
         b_avy_ff <= DiffW'(a_qy_ff) - DiffW'(a_sy_ff);

         c_abx_ff <= b_abx_ff; c_aby_ff <= b_aby_ff;
         c_avx_ff <= b_avx_ff; c_avy_ff <= b_avy_ff;
         c_px_ff  <= ProdW'(b_avx_ff) * ProdW'(b_abx_ff);
         c_py_ff  <= ProdW'(b_avy_ff) * ProdW'(b_aby_ff);
         c_qx_ff  <= ProdW'(b_abx_ff) * ProdW'(b_abx_ff);
         c_qy_ff  <= ProdW'(b_aby_ff) * ProdW'(b_aby_ff);

         d_abx_ff <= c_abx_ff; d_aby_ff <= c_aby_ff;
         d_avx_ff <= c_avx_ff; d_avy_ff <= c_avy_ff;
         d_zero_ff <= zero_c;
         d_one_ff  <= one_c;
         d_den_ff  <= den_c;
         // drop the remainder outside the open interval; quotient is unused there
         d_rem_ff  <= (zero_c || one_c) ? '0 : $unsigned(num_c);

         for (int k = 0; k < DivSteps; k++) begin
            dv_rem_ff[k] <= dv_rem_in[k];
            dv_q_ff[k]   <= dv_q_in[k];
            dv_den_ff[k]  <= (k == 0) ? d_den_ff  : dv_den_ff[k-1];
            dv_zero_ff[k] <= (k == 0) ? d_zero_ff : dv_zero_ff[k-1];
            dv_one_ff[k]  <= (k == 0) ? d_one_ff  : dv_one_ff[k-1];
            dv_abx_ff[k]  <= (k == 0) ? d_abx_ff  : dv_abx_ff[k-1];
            dv_aby_ff[k]  <= (k == 0) ? d_aby_ff  : dv_aby_ff[k-1];
            dv_avx_ff[k]  <= (k == 0) ? d_avx_ff  : dv_avx_ff[k-1];
            dv_avy_ff[k]  <= (k == 0) ? d_avy_ff  : dv_avy_ff[k-1];
         end

         e_avx_ff <= dv_avx_ff[DivSteps-1];
         e_avy_ff <= dv_avy_ff[DivSteps-1];
         e_tx_ff  <= OffW'($signed({1'b0, t_c})) * OffW'(dv_abx_ff[DivSteps-1]);
         e_ty_ff  <= OffW'($signed({1'b0, t_c})) * OffW'(dv_aby_ff[DivSteps-1]);

         f_mx_ff <= ax_c[MagW+7:8];
         f_my_ff <= ay_c[MagW+7:8];

         g_sx_ff <= (2*MagW)'(f_mx_ff) * (2*MagW)'(f_mx_ff);
         g_sy_ff <= (2*MagW)'(f_my_ff) * (2*MagW)'(f_my_ff);

         h_n_ff <= RadW'(g_sx_ff) + RadW'(g_sy_ff);

         for (int k = 0; k < SqSteps; k++) begin
            sq_n_ff[k] <= sq_n_in[k];
            sq_r_ff[k] <= sq_r_in[k];
         end

         o_dist_ff <= sq_r_ff[SqSteps-1][DistW+7:8];
      end
   end

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = {7'd0, o_dist_ff};

   // a clamp cannot pick both ends at once
   a_clamp_excl: assert property (@(posedge clock) disable iff (reset)
      d_v_ff |-> !(d_zero_ff && d_one_ff))
      else $error("clamp flags both set");
   // divider remainder stays below the squared length
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      dv_v_ff[DivSteps-1] |-> (dv_rem_ff[DivSteps-1] < dv_den_ff[DivSteps-1]
                               || dv_den_ff[DivSteps-1] == '0))
      else $error("divider remainder out of range");
   // root never exceeds the result width before truncation
   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      sq_v_ff[SqSteps-1] |-> (sq_r_ff[SqSteps-1][RootW-1:DistW+8] == '0))
      else $error("root out of range");
   // a stalled output stalls intake
   a_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("intake during output stall");
endmodule
